>>> rtl/otc_pkg.sv
`timescale 1ns / 1ps

package otc_pkg;

  localparam int unsigned KhzW     = 16;
  localparam int unsigned TrimW    = 8;
  localparam int unsigned AttW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WinHiW   = KhzW + 1;

  localparam logic [KhzW-1:0]  TargetReset   = 16'd8000;
  localparam logic [TrimW-1:0] TrimReset     = 8'd128;
  localparam logic [AttW-1:0]  AttemptsReset = 8'd10;

  // trim codes strictly between these two are skipped over
  localparam logic [TrimW-1:0] HoleLow  = 8'd96;
  localparam logic [TrimW-1:0] HoleHigh = 8'd128;
  localparam logic [TrimW-1:0] HoleJump = 8'd32;

  // offset / 128 sets the step size
  localparam int unsigned StepShift = 7;

  // x / 100 == ((x >> 2) * 5243) >> 17, exact for all 16-bit x
  localparam logic [12:0] MarginMul   = 13'd5243;
  localparam int unsigned MarginShift = 17;
  localparam int unsigned MarginProdW = 27;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET    = 2'd0,
    CFG_INIT_TRIM = 2'd1,
    CFG_MAX_ATT   = 2'd2
  } otc_cfg_e;

  typedef struct packed {
    logic [KhzW-1:0] measured_khz;
  } otc_meas_t;

  typedef struct packed {
    logic [TrimW-1:0] trim_value;
    logic             locked;
    logic             exhausted;
    logic [AttW-1:0]  attempts_used;
  } otc_result_t;

  typedef struct packed {
    logic [TrimW-1:0] trim;
    logic [AttW-1:0]  attempts;
    logic             locked;
    logic             exhausted;
  } otc_state_t;

  // target / 100 by reciprocal multiplication
  function automatic logic [KhzW-1:0] otc_margin(input logic [KhzW-1:0] target);
    logic [MarginProdW-1:0] prod;
    prod = MarginProdW'(target[KhzW-1:2]) * MarginProdW'(MarginMul);
    return KhzW'(prod[MarginProdW-1:MarginShift]);
  endfunction

endpackage

>>> rtl/otc_stream_if.sv
`timescale 1ns / 1ps

interface otc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/otc_step.sv
`timescale 1ns / 1ps

module otc_step (
  input  otc_pkg::otc_state_t              cur_i,
  input  logic [otc_pkg::KhzW-1:0]         meas_i,
  input  logic [otc_pkg::KhzW-1:0]         target_i,
  input  logic [otc_pkg::WinHiW-1:0]       win_hi_i,
  input  logic [otc_pkg::KhzW-1:0]         win_lo_i,
  input  logic [otc_pkg::AttW-1:0]         max_att_i,
  output otc_pkg::otc_state_t              nxt_o
);
  import otc_pkg::*;

  logic             above;
  logic             in_window;
  logic [KhzW-1:0]  offs;
  logic [TrimW-1:0] step;
  logic [TrimW-1:0] t_move;
  logic             in_hole;
  logic [TrimW-1:0] t_new;
  logic [AttW-1:0]  att_inc;

  assign above     = meas_i > target_i;
  assign in_window = ({1'b0, meas_i} < win_hi_i) && (meas_i > win_lo_i);
  assign offs      = above ? (meas_i - target_i) : (target_i - meas_i);
  assign step      = TrimW'(offs[KhzW-1:StepShift]) + TrimW'(1);
  assign t_move    = above ? (cur_i.trim - step) : (cur_i.trim + step);
  assign in_hole   = (t_move > HoleLow) && (t_move < HoleHigh);
  assign att_inc   = cur_i.attempts + AttW'(1);

  always_comb begin
    if (!in_hole) begin
      t_new = t_move;
    end else if (above) begin
      t_new = t_move - HoleJump;
    end else begin
      t_new = t_move + HoleJump;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.locked || cur_i.exhausted) begin
      nxt_o = cur_i;
    end else if (cur_i.attempts >= max_att_i) begin
      // limit lowered to or below the count already used
      nxt_o.exhausted = 1'b1;
    end else begin
      nxt_o.attempts = att_inc;
      if (in_window) begin
        nxt_o.locked = 1'b1;
      end else begin
        nxt_o.trim      = t_new;
        nxt_o.exhausted = att_inc >= max_att_i;
      end
    end
  end

endmodule

>>> rtl/oscillator_trim_calibration.sv
`timescale 1ns / 1ps

// Path: an accepted item is held in the input register, then moves to the result register
// when the result side is free; the result handshake is made from the result register.
// Throughput: one item per cycle while the result side is not stalled; the trim update is a combinational compare/add.
// The output register decouples the sides so a stalled result still lets one item in.
// Reset: config registers return to 8000 kHz / 10 attempts, trim loads the initial value 128,
// attempt count and lock/exhausted flags clear, pipeline empties.
module oscillator_trim_calibration (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [otc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [otc_pkg::CfgDataW-1:0]    cfg_data_i,
  otc_stream_if.sink                      meas_i,
  otc_stream_if.source                    res_o
);
  import otc_pkg::*;

  logic [KhzW-1:0]   target_q;
  logic [WinHiW-1:0] win_hi_q;
  logic [KhzW-1:0]   win_lo_q;
  logic [AttW-1:0]   max_att_q;

  otc_state_t        state_q;
  otc_state_t        state_d;

  logic              s1_valid_q;
  logic [KhzW-1:0]   meas_q;
  logic              res_valid_q;
  otc_result_t       res_q;

  logic              advance;
  logic              meas_take;
  logic [KhzW-1:0]   cfg_target;
  logic [KhzW-1:0]   cfg_margin;

  assign advance   = !res_valid_q || res_o.ready;
  assign meas_take = meas_i.valid && meas_i.ready;

  assign meas_i.ready  = !s1_valid_q || advance;
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  assign cfg_target = cfg_data_i[KhzW-1:0];
  assign cfg_margin = otc_margin(cfg_target);

  otc_step u_step (
    .cur_i     (state_q),
    .meas_i    (meas_q),
    .target_i  (target_q),
    .win_hi_i  (win_hi_q),
    .win_lo_i  (win_lo_q),
    .max_att_i (max_att_q),
    .nxt_o     (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= TargetReset;
      win_hi_q      <= WinHiW'(TargetReset) + WinHiW'(otc_margin(TargetReset));
      win_lo_q      <= TargetReset - otc_margin(TargetReset);
      max_att_q     <= AttemptsReset;
      state_q       <= '{trim: TrimReset, attempts: '0, locked: 1'b0, exhausted: 1'b0};
      s1_valid_q    <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (otc_cfg_e'(cfg_idx_i))
          CFG_TARGET: begin
            // window bounds are fixed at write time
            target_q <= cfg_target;
            win_hi_q <= WinHiW'(cfg_target) + WinHiW'(cfg_margin);
            win_lo_q <= cfg_target - cfg_margin;
          end
          CFG_INIT_TRIM: begin
            if (state_q.attempts == '0 && !state_q.locked && !state_q.exhausted) begin
              state_q.trim <= cfg_data_i[TrimW-1:0];
            end
          end
          CFG_MAX_ATT: begin
            max_att_q <= cfg_data_i[AttW-1:0];
          end
          default: begin
          end
        endcase
      end else if (advance && s1_valid_q) begin
        state_q <= state_d;
      end
      if (meas_i.ready) begin
        s1_valid_q <= meas_i.valid;
      end
      if (advance) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_take) begin
      meas_q <= meas_i.payload.measured_khz;
    end
    if (advance && s1_valid_q) begin
      res_q.trim_value    <= state_d.trim;
      res_q.locked        <= state_d.locked;
      res_q.exhausted     <= state_d.exhausted;
      res_q.attempts_used <= state_d.attempts;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.locked && state_q.exhausted))
    else $error("lock and exhausted both set");

  a_lock_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.locked |=> state_q.locked && $stable(state_q.trim) && $stable(state_q.attempts))
    else $error("locked state changed");

  a_exhaust_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.exhausted |=> state_q.exhausted && $stable(state_q.attempts))
    else $error("exhausted state changed");

  a_stage_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(meas_q))
    else $error("input stage item lost under stall");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_valid_q) && !cfg_we_i |=> $stable(state_q))
    else $error("state moved without an item");

endmodule
